// ===== hdl/pet_pkg.sv =====
`timescale 1ns / 1ps

package pet_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int LEVEL_COUNT         = 5;
   localparam int TABLE_SIZE          = 5;

   // sensitivity register
   localparam int          SENS_BITS  = 3;
   localparam logic [2:0]  SENS_RESET = 3'd2;

   // highest table index that the sensitivity setting may reach
   localparam int IDX_LIMIT_RAW = (LEVEL_COUNT > TABLE_SIZE) ? TABLE_SIZE : LEVEL_COUNT;
   localparam int IDX_LIMIT     = (IDX_LIMIT_RAW < 1) ? 1 : IDX_LIMIT_RAW;
   localparam logic [2:0] IDX_MAX = 3'(IDX_LIMIT - 1);

   // divisor and remainder of the serial divider
   localparam int WIN_BITS = 5;
   localparam int REM_BITS = 4;
   // growth of the weighted sum over the sample width (window up to 16)
   localparam int SUM_GROWTH = 4;

   localparam int THR_BITS      = 8;
   localparam int STRONG_MARGIN = 30;

   typedef logic [1:0] code_type;

   localparam code_type EVT_NONE   = 2'd0;
   localparam code_type EVT_WEAK   = 2'd1;
   localparam code_type EVT_STRONG = 2'd2;

   localparam code_type LVL_NONE = 2'd0;
   localparam code_type LVL_LOW  = 2'd1;
   localparam code_type LVL_HIGH = 2'd2;

   function automatic logic [2:0] sat_index(input logic [SENS_BITS-1:0] sens);
      logic [2:0] idx;
      idx = sens;
      if (idx > IDX_MAX) begin
         idx = IDX_MAX;
      end
      return idx;
   endfunction

   function automatic logic [WIN_BITS-1:0] window_of(input logic [2:0] idx);
      logic [WIN_BITS-1:0] w;
      case (idx)
         3'd0:    w = 5'd16;
         3'd1:    w = 5'd12;
         3'd2:    w = 5'd8;
         3'd3:    w = 5'd4;
         default: w = 5'd2;
      endcase
      return w;
   endfunction

   function automatic logic [THR_BITS-1:0] thresh_of(input logic [2:0] idx);
      logic [THR_BITS-1:0] t;
      case (idx)
         3'd0:    t = 8'd200;
         3'd1:    t = 8'd150;
         3'd2:    t = 8'd100;
         3'd3:    t = 8'd50;
         default: t = 8'd25;
      endcase
      return t;
   endfunction

endpackage

// ===== hdl/pet_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, msb first
module pet_div import pet_pkg::*; #(
   parameter int NUM_BITS = SAMPLE_BITS_DEFAULT + SUM_GROWTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [WIN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [WIN_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [WIN_BITS-1:0] trial;
   logic [WIN_BITS-1:0] diff;
   logic                qbit;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_BITS-1]};
      diff  = trial - den_ff;
      qbit  = (trial >= den_ff);
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], qbit};
         rem_in = qbit ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_BITS'(NUM_BITS);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = busy_ff && (cnt_ff == CNT_BITS'(1));
   assign quot = num_ff;

endmodule

// ===== hdl/piezo_envelope_trigger.sv =====
`timescale 1ns / 1ps

// Piezo envelope trigger. Each sample beat updates an exponential envelope,
// env = (env*(N-1) + sample) / N truncated, with window N and threshold T picked
// by the sensitivity register (N 16,12,8,4,2 and T 200,150,100,50,25; values
// above the last entry saturate). One result beat per sample carries the new
// envelope and an event code: strong when the envelope reaches T+30 and the
// trigger level is not yet high, weak when it reaches T from level none; the
// level falls back to none once the envelope drops below T/2. A sample is taken
// only in idle; it then passes through the bit-serial divider, which produces one
// quotient bit per cycle over the SAMPLE_BITS+4 bit weighted sum, then through a
// commit state and back to idle before the next sample is taken.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; the commit stalls only if that register is still full.
// Write csr_wdata only while no sample is in flight.
module piezo_envelope_trigger import pet_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // sample
   // result beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+9)/8)*8-1:0]     rsp_tdata,   // event_code, envelope_value
   // sensitivity register
   input  logic                                 csr_wen,
   input  logic [SENS_BITS-1:0]                 csr_wdata
);

   localparam int SUM_BITS = SAMPLE_BITS + SUM_GROWTH;

   // control states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [SENS_BITS-1:0]   sens_ff;
   logic [SAMPLE_BITS-1:0] env_ff;
   code_type               level_ff, level_in;
   logic                   rsp_valid_ff;
   code_type               rsp_code_ff, code_in;
   logic [SAMPLE_BITS-1:0] rsp_env_ff;

   logic [2:0]             idx;
   logic [WIN_BITS-1:0]    win;
   logic [THR_BITS-1:0]    thr;
   logic [SAMPLE_BITS-1:0] strong_lim, weak_lim, release_lim;
   logic [SUM_BITS-1:0]    wsum;
   logic                   accept;
   logic                   commit;
   logic                   div_done;
   logic [SUM_BITS-1:0]    div_quot;
   logic [SAMPLE_BITS-1:0] env_new;

   // table lookup, saturating index
   assign idx = sat_index(sens_ff);
   assign win = window_of(idx);
   assign thr = thresh_of(idx);

   assign strong_lim  = SAMPLE_BITS'(thr) + SAMPLE_BITS'(STRONG_MARGIN);
   assign weak_lim    = SAMPLE_BITS'(thr);
   assign release_lim = SAMPLE_BITS'(thr >> 1);

   // weighted sum env*(N-1) + sample, fits SAMPLE_BITS+4 bits since N <= 16
   assign wsum = SUM_BITS'(env_ff) * SUM_BITS'(win - WIN_BITS'(1))
               + SUM_BITS'(req_tdata[SAMPLE_BITS-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // commit once the output register is free or being drained
   assign commit     = (state_ff == ST_POST) && (!rsp_valid_ff || rsp_tready);

   pet_div #(
      .NUM_BITS (SUM_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .numer (wsum),
      .denom (win),
      .done  (div_done),
      .quot  (div_quot)
   );

   // quotient of a weighted average never exceeds the sample range
   assign env_new = div_quot[SAMPLE_BITS-1:0];

   // hysteretic trigger decision
   always_comb begin
      code_in  = EVT_NONE;
      level_in = level_ff;
      if (env_new >= strong_lim) begin
         if (level_ff != LVL_HIGH) begin
            code_in  = EVT_STRONG;
            level_in = LVL_HIGH;
         end
      end else if (env_new >= weak_lim) begin
         if (level_ff == LVL_NONE) begin
            code_in  = EVT_WEAK;
            level_in = LVL_LOW;
         end
      end else if (env_new < release_lim) begin
         level_in = LVL_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sens_ff      <= SENS_RESET;
         env_ff       <= '0;
         level_ff     <= LVL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            sens_ff <= csr_wdata;
         end
         if (commit) begin
            env_ff       <= env_new;
            level_ff     <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_code_ff <= code_in;
         rsp_env_ff  <= env_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[1:0]             = rsp_code_ff;
      rsp_tdata[2 +: SAMPLE_BITS] = rsp_env_ff;
   end

endmodule

// ===== dv/envelope_trigger_checker.sv =====
`timescale 1ns / 1ps

module envelope_trigger_checker import pet_pkg::*; #(
   parameter int SAMPLE_W = SAMPLE_BITS_DEFAULT,
   parameter int REQ_W    = ((SAMPLE_W+7)/8)*8,
   parameter int RSP_W    = ((SAMPLE_W+9)/8)*8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_wen,
   input  logic [SENS_BITS-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   awaited_count
);

   typedef struct packed {
      code_type            event_code;
      logic [SAMPLE_W-1:0] envelope_value;
   } trigger_outcome_type;

   localparam int WINDOW_BY_IDX [TABLE_SIZE] = '{16, 12, 8, 4, 2};
   localparam int THRESH_BY_IDX [TABLE_SIZE] = '{200, 150, 100, 50, 25};

   logic [SENS_BITS-1:0] sens_copy;
   logic [SAMPLE_W-1:0]  env_copy;
   code_type             level_copy;
   trigger_outcome_type  outcomes_due[$];

   // one envelope step plus the hysteresis decision
   function automatic trigger_outcome_type advance_envelope(input logic [SAMPLE_W-1:0] sample);
      trigger_outcome_type res;
      int idx;
      int win;
      int thr;
      int acc;
      idx = (sens_copy > IDX_MAX) ? int'(IDX_MAX) : int'(sens_copy);
      win = WINDOW_BY_IDX[idx];
      thr = THRESH_BY_IDX[idx];
      acc = (int'(env_copy) * (win - 1) + int'(sample)) / win;
      env_copy = acc[SAMPLE_W-1:0];
      res.event_code = EVT_NONE;
      if (int'(env_copy) >= thr + STRONG_MARGIN) begin
         if (level_copy != LVL_HIGH) begin
            res.event_code = EVT_STRONG;
            level_copy     = LVL_HIGH;
         end
      end else if (int'(env_copy) >= thr) begin
         if (level_copy == LVL_NONE) begin
            res.event_code = EVT_WEAK;
            level_copy     = LVL_LOW;
         end
      end else if (int'(env_copy) < thr / 2) begin
         level_copy = LVL_NONE;
      end
      res.envelope_value = env_copy;
      return res;
   endfunction

   always @(posedge clock) begin
      trigger_outcome_type want;
      code_type got_code;
      logic [SAMPLE_W-1:0] got_env;
      if (reset) begin
         sens_copy  = SENS_RESET;
         env_copy   = '0;
         level_copy = LVL_NONE;
         outcomes_due.delete();
      end else begin
         // result side first: a result never belongs to a sample taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got_code = rsp_tdata[1:0];
            got_env  = rsp_tdata[2 +: SAMPLE_W];
            if (outcomes_due.size() == 0) begin
               $error("result beat with nothing outstanding: event_code %0d envelope_value %0d",
                      got_code, got_env);
               mismatch_count++;
            end else begin
               want = outcomes_due.pop_front();
               if (got_code !== want.event_code) begin
                  $error("event_code: expected %0d, actual %0d", want.event_code, got_code);
                  mismatch_count++;
               end
               if (got_env !== want.envelope_value) begin
                  $error("envelope_value: expected %0d, actual %0d",
                         want.envelope_value, got_env);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            outcomes_due.push_back(advance_envelope(req_tdata[SAMPLE_W-1:0]));
         end
         if (csr_wen) begin
            sens_copy = csr_wdata;
         end
      end
      awaited_count = outcomes_due.size();
   end

endmodule

// ===== dv/piezo_envelope_trigger_test.sv =====
`timescale 1ns / 1ps

module piezo_envelope_trigger_test;
   import pet_pkg::*;

   localparam int SAMPLE_W   = SAMPLE_BITS_DEFAULT;
   localparam int REQ_W      = ((SAMPLE_W+7)/8)*8;
   localparam int RSP_W      = ((SAMPLE_W+9)/8)*8;
   localparam int HALF_CYCLE = 6;
   localparam int CYCLE_CAP  = 600000;   // far above the slowest legal run
   localparam int HOLD_SPAN  = 400;      // long receiver hold-off, in cycles
   localparam int DRAIN_WAIT = 40;       // extra wait once the checker has nothing outstanding
   localparam int PHASE_LEN  = 100;
   localparam int PHASE_NUM  = 10;

   // thresholds used only to steer the random amplitudes around the trigger band
   localparam int STEER_THR [TABLE_SIZE] = '{200, 150, 100, 50, 25};

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;   // sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;         // event_code, envelope_value
   logic                 csr_wen    = 1'b0;
   logic [SENS_BITS-1:0] csr_wdata  = '0;

   int  mismatch_count;
   int  awaited_count;
   int  cycle_count  = 0;
   int  sender_idle  = 0;   // percent of cycles the sample side sits idle
   int  rsp_stall    = 0;   // percent of cycles the result side stalls
   bit  hold_request = 0;
   int  active_sens  = SENS_RESET;

   piezo_envelope_trigger dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   envelope_trigger_checker #(.SAMPLE_W(SAMPLE_W)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #HALF_CYCLE clock = ~clock;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off counted here
   initial begin
      int k;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (k = 1; k < HOLD_SPAN; k++) begin
               @(posedge clock);
            end
            hold_request = 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall);
         end
      end
   end

   // offer one sample beat; handshake is judged on values settled at the falling edge
   task automatic offer_sample(input logic [SAMPLE_W-1:0] sample);
      logic taken;
      while ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample);
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
   endtask

   // drop valid, let the block drain, then write the sensitivity register
   task automatic write_sensitivity(input logic [SENS_BITS-1:0] value);
      req_tvalid <= 1'b0;
      // count settles after the edge that took the last sample
      @(negedge clock);
      wait (awaited_count == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      active_sens = value;
   endtask

   // bursts of a steady amplitude near the trigger band, then quiet stretches
   task automatic random_burst_phase(input int item_total);
      int sent;
      int run_len;
      int amp;
      int thr;
      int j;
      sent = 0;
      thr  = STEER_THR[(active_sens > int'(IDX_MAX)) ? int'(IDX_MAX) : active_sens];
      while (sent < item_total) begin
         if ($urandom_range(0, 7) == 0) begin
            amp = $urandom_range(0, 4095);
         end else begin
            amp = $urandom_range(0, 3 * thr);
         end
         run_len = $urandom_range(3, 24);
         for (j = 0; j < run_len && sent < item_total; j++) begin
            offer_sample(SAMPLE_W'((amp + $urandom_range(0, 20) > 4095) ? 4095
                                   : amp + $urandom_range(0, 20)));
            sent++;
         end
         run_len = $urandom_range(0, 12);
         for (j = 0; j < run_len && sent < item_total; j++) begin
            // mostly silence, sometimes a stray spike of random amplitude
            offer_sample(($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom) : '0);
            sent++;
         end
      end
   endtask

   initial begin
      int p;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sensitivity: full-scale hit gives a strong event, then alternating bit patterns
      offer_sample(12'hfff);
      offer_sample(12'h555);
      offer_sample(12'haaa);

      // shortest window: decay to release, weak crossing, strong crossing, release again
      write_sensitivity(3'd4);
      for (n = 0; n < 7; n++) begin
         offer_sample('0);
      end
      offer_sample(12'd54);
      offer_sample(12'd80);
      for (n = 0; n < 3; n++) begin
         offer_sample('0);
      end

      // settings past the table end saturate to the last entry
      write_sensitivity(3'd7);
      offer_sample(12'hfff);
      offer_sample('0);
      write_sensitivity(3'd0);
      offer_sample(12'hfff);
      write_sensitivity(3'd1);
      offer_sample('0);
      write_sensitivity(3'd6);
      offer_sample(12'd300);
      write_sensitivity(3'd5);
      offer_sample(12'd1);
      write_sensitivity(3'd3);
      offer_sample(12'd4094);

      // random phases walking through every setting and idle pattern
      for (p = 0; p < PHASE_NUM; p++) begin
         write_sensitivity(SENS_BITS'((p * 3 + 2) % 8));
         case (p % 4)
            0: begin
               sender_idle = 0;
               rsp_stall   = 0;
            end
            1: begin
               sender_idle = 60;
               rsp_stall   = 0;
            end
            2: begin
               sender_idle = 0;
               rsp_stall   = 60;
            end
            default: begin
               sender_idle = 13;
               rsp_stall   = 13;
            end
         endcase
         // long back-pressure while samples keep coming, so the input stalls
         if (p == 4) begin
            hold_request = 1;
         end
         random_burst_phase(PHASE_LEN);
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      wait (awaited_count == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== piezo_envelope_trigger.f =====
hdl/pet_pkg.sv
hdl/pet_div.sv
hdl/piezo_envelope_trigger.sv
dv/envelope_trigger_checker.sv
dv/piezo_envelope_trigger_test.sv
